/* hdl/hvt_pkg.sv */
// shared types and constants for the homogeneous 2d vertex transform
`default_nettype none
package hvt_pkg;
	localparam int COEF_WIDTH = 16;
	localparam int ROW_WIDTH = 3 * COEF_WIDTH;
	localparam int INDEX_WIDTH = 2;
	localparam int STATUS_WIDTH = 2;

	localparam logic [INDEX_WIDTH-1:0] REG_ROW_X = 2'd0;
	localparam logic [INDEX_WIDTH-1:0] REG_ROW_Y = 2'd1;
	localparam logic [INDEX_WIDTH-1:0] REG_ROW_W = 2'd2;

	localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] STATUS_SAT = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] STATUS_WZERO = 2'd2;

	localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = 48'h0000_0000_0100;
	localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = 48'h0000_0100_0000;
	localparam logic [ROW_WIDTH-1:0] ROW_W_RESET = 48'h0100_0000_0000;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic wzero;
		logic last;
	} hvt_side_t;
endpackage
`default_nettype wire

/* hdl/hvt_div_cell.sv */
// one restoring division cell: one quotient bit for each of the x and y lanes
`default_nettype none
module hvt_div_cell
	import hvt_pkg::*;
#(
	parameter int W = 64,
	parameter int QW = 18,
	parameter int K = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [W-1:0]  in_rem_x,
	input  wire logic [W-1:0]  in_rem_y,
	input  wire logic [W-1:0]  in_den,
	input  wire logic [QW-1:0] in_q_x,
	input  wire logic [QW-1:0] in_q_y,
	input  wire hvt_side_t     in_side,
	output logic               out_valid,
	output logic [W-1:0]       out_rem_x,
	output logic [W-1:0]       out_rem_y,
	output logic [W-1:0]       out_den,
	output logic [QW-1:0]      out_q_x,
	output logic [QW-1:0]      out_q_y,
	output hvt_side_t          out_side
);
	logic [W-1:0] den_sh;
	logic ge_x, ge_y;

	assign den_sh = in_den << K;
	assign ge_x = in_rem_x >= den_sh;
	assign ge_y = in_rem_y >= den_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem_x <= ge_x ? in_rem_x - den_sh : in_rem_x;
			out_rem_y <= ge_y ? in_rem_y - den_sh : in_rem_y;
			out_den <= in_den;
			out_q_x <= {in_q_x[QW-2:0], ge_x};
			out_q_y <= {in_q_y[QW-2:0], ge_y};
			out_side <= in_side;
		end
	end
endmodule
`default_nettype wire

/* hdl/homogeneous_2d_vertex_transform.sv */
// top level: matrix multiply stages, a chain of division cells and the output register
// throughput: one vertex per cycle while the output is taken, set by the fully pipelined chain of division cells
// the whole pipeline stalls together while the output request is not taken
// reset: asynchronous, active low; clears valid bits and loads the identity matrix
`default_nettype none
module homogeneous_2d_vertex_transform
	import hvt_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [INDEX_WIDTH-1:0]        cfg_index,
	input  wire logic [ROW_WIDTH-1:0]          cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] vertex_x,
	input  wire logic signed [COORD_WIDTH-1:0] vertex_y,
	input  wire logic                          last_vertex,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      projected_x,
	output logic signed [COORD_WIDTH-1:0]      projected_y,
	output logic [STATUS_WIDTH-1:0]            status,
	output logic                               last_out
);
	localparam int MW = (COORD_WIDTH > FRACTION_BITS) ? COORD_WIDTH : FRACTION_BITS;
	localparam int PW = COORD_WIDTH + COEF_WIDTH;
	localparam int NW = MW + COEF_WIDTH + 2;
	localparam int QW = COORD_WIDTH + 2;
	localparam int W = NW + FRACTION_BITS + QW;
	localparam int NCELL = QW;

	logic [ROW_WIDTH-1:0] row_x_q, row_y_q, row_w_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q <= ROW_X_RESET;
			row_y_q <= ROW_Y_RESET;
			row_w_q <= ROW_W_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_X: row_x_q <= cfg_wdata;
				REG_ROW_Y: row_y_q <= cfg_wdata;
				REG_ROW_W: row_w_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en = out_ready || !out_valid;
	assign in_ready = en;

	// stage 1: six products
	logic valid_s1, last_s1;
	logic signed [PW-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1, pwx_s1, pwy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s1 <= PW'($signed(row_x_q[15:0]) * vertex_x);
			pxy_s1 <= PW'($signed(row_x_q[31:16]) * vertex_y);
			pyx_s1 <= PW'($signed(row_y_q[15:0]) * vertex_x);
			pyy_s1 <= PW'($signed(row_y_q[31:16]) * vertex_y);
			pwx_s1 <= PW'($signed(row_w_q[15:0]) * vertex_x);
			pwy_s1 <= PW'($signed(row_w_q[31:16]) * vertex_y);
			last_s1 <= last_vertex;
		end
	end

	// stage 2: row sums, constant column scaled by one
	logic valid_s2, last_s2;
	logic signed [NW-1:0] tx_s2, ty_s2, tw_s2;
	logic signed [NW-1:0] cx, cy, cw;

	assign cx = NW'($signed(row_x_q[47:32])) <<< FRACTION_BITS;
	assign cy = NW'($signed(row_y_q[47:32])) <<< FRACTION_BITS;
	assign cw = NW'($signed(row_w_q[47:32])) <<< FRACTION_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s2 <= NW'(pxx_s1) + NW'(pxy_s1) + cx;
			ty_s2 <= NW'(pyx_s1) + NW'(pyy_s1) + cy;
			tw_s2 <= NW'(pwx_s1) + NW'(pwy_s1) + cw;
			last_s2 <= last_s1;
		end
	end

	// stage 3: magnitudes and signs, scaled dividends
	logic valid_s3;
	logic [W-1:0] remx_s3, remy_s3, den_s3;
	hvt_side_t side_s3;
	logic [NW-1:0] mag_x, mag_y, mag_w;

	assign mag_x = tx_s2[NW-1] ? NW'(-tx_s2) : NW'(tx_s2);
	assign mag_y = ty_s2[NW-1] ? NW'(-ty_s2) : NW'(ty_s2);
	assign mag_w = tw_s2[NW-1] ? NW'(-tw_s2) : NW'(tw_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			remx_s3 <= W'(mag_x) << FRACTION_BITS;
			remy_s3 <= W'(mag_y) << FRACTION_BITS;
			den_s3 <= W'(mag_w);
			side_s3.neg_x <= tx_s2[NW-1] != tw_s2[NW-1];
			side_s3.neg_y <= ty_s2[NW-1] != tw_s2[NW-1];
			side_s3.wzero <= tw_s2 == '0;
			side_s3.last <= last_s2;
		end
	end

	// division chain, most significant quotient bit first; the top bit flags overflow
	logic            cv   [0:NCELL];
	logic [W-1:0]    crx  [0:NCELL];
	logic [W-1:0]    cry  [0:NCELL];
	logic [W-1:0]    cden [0:NCELL];
	logic [QW-1:0]   cqx  [0:NCELL];
	logic [QW-1:0]   cqy  [0:NCELL];
	hvt_side_t       cside[0:NCELL];

	assign cv[0] = valid_s3;
	assign crx[0] = remx_s3;
	assign cry[0] = remy_s3;
	assign cden[0] = den_s3;
	assign cqx[0] = '0;
	assign cqy[0] = '0;
	assign cside[0] = side_s3;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		hvt_div_cell #(
			.W (W),
			.QW(QW),
			.K (NCELL - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (cv[i]),
			.in_rem_x (crx[i]),
			.in_rem_y (cry[i]),
			.in_den   (cden[i]),
			.in_q_x   (cqx[i]),
			.in_q_y   (cqy[i]),
			.in_side  (cside[i]),
			.out_valid(cv[i+1]),
			.out_rem_x(crx[i+1]),
			.out_rem_y(cry[i+1]),
			.out_den  (cden[i+1]),
			.out_q_x  (cqx[i+1]),
			.out_q_y  (cqy[i+1]),
			.out_side (cside[i+1])
		);
	end

	// output stage: clamp, sign, status
	logic [QW-1:0] qx, qy;
	hvt_side_t side_f;
	logic [COORD_WIDTH:0] lim_x, lim_y, val_x, val_y;
	logic sat_x, sat_y;

	assign qx = cqx[NCELL];
	assign qy = cqy[NCELL];
	assign side_f = cside[NCELL];
	assign lim_x = side_f.neg_x ? (COORD_WIDTH+1)'(1) << (COORD_WIDTH - 1)
		: ((COORD_WIDTH+1)'(1) << (COORD_WIDTH - 1)) - 1'b1;
	assign lim_y = side_f.neg_y ? (COORD_WIDTH+1)'(1) << (COORD_WIDTH - 1)
		: ((COORD_WIDTH+1)'(1) << (COORD_WIDTH - 1)) - 1'b1;
	assign sat_x = qx[QW-1] || (qx[COORD_WIDTH:0] > lim_x);
	assign sat_y = qy[QW-1] || (qy[COORD_WIDTH:0] > lim_y);
	assign val_x = sat_x ? lim_x : qx[COORD_WIDTH:0];
	assign val_y = sat_y ? lim_y : qy[COORD_WIDTH:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= cv[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_out <= side_f.last;
			if (side_f.wzero) begin
				projected_x <= '0;
				projected_y <= '0;
				status <= STATUS_WZERO;
			end else begin
				projected_x <= side_f.neg_x ? COORD_WIDTH'(-val_x) : COORD_WIDTH'(val_x);
				projected_y <= side_f.neg_y ? COORD_WIDTH'(-val_y) : COORD_WIDTH'(val_y);
				status <= (sat_x || sat_y) ? STATUS_SAT : STATUS_OK;
			end
		end
	end

`ifndef SYNTH
	a_wzero_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_WZERO |-> projected_x == '0 && projected_y == '0)
		else $error("zero w result with nonzero coordinates");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STATUS_OK || status == STATUS_SAT || status == STATUS_WZERO)
		else $error("undefined status code");
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (out_ready || !out_valid))
		else $error("input ready does not follow output stall");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(projected_x) && $stable(status))
		else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

/* tb/tb_homogeneous_2d_vertex_transform.sv */
// testbench for the homogeneous 2d vertex transform: directed table, random vertices, predictor check
`default_nettype none
module tb_homogeneous_2d_vertex_transform
	import hvt_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 16;
	localparam int FB = 8;
	localparam int LATENCY = CW + 6;

	typedef struct {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic [STATUS_WIDTH-1:0] st;
		logic lst;
	} vertex_result_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic lst;
		bit known;
		vertex_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [INDEX_WIDTH-1:0] cfg_index = REG_ROW_X;
	logic [ROW_WIDTH-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] vertex_x = '0;
	logic signed [CW-1:0] vertex_y = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CW-1:0] projected_x;
	logic signed [CW-1:0] projected_y;
	logic [STATUS_WIDTH-1:0] status;
	logic last_out;

	logic [ROW_WIDTH-1:0] row_x = ROW_X_RESET;
	logic [ROW_WIDTH-1:0] row_y = ROW_Y_RESET;
	logic [ROW_WIDTH-1:0] row_w = ROW_W_RESET;

	vertex_result_t projected_queue[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	homogeneous_2d_vertex_transform #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) dut (.*);

	always #10 clk = ~clk;

	function automatic longint row_dot(logic [ROW_WIDTH-1:0] row, longint x, longint y);
		longint c0, c1, c2;
		c0 = longint'($signed(row[15:0]));
		c1 = longint'($signed(row[31:16]));
		c2 = longint'($signed(row[47:32]));
		return c0 * x + c1 * y + c2 * (longint'(1) << FB);
	endfunction

	// truncating divide toward zero with clamp to the coordinate range
	function automatic logic [CW-1:0] divide_clamp(longint num, longint den, inout bit sat);
		bit neg;
		longint unsigned mn, md, lim, ip, rem, val;
		neg = (num < 0) != (den < 0);
		mn = num < 0 ? -num : num;
		md = den < 0 ? -den : den;
		lim = neg ? (64'd1 << (CW - 1)) : (64'd1 << (CW - 1)) - 1;
		ip = mn / md;
		rem = mn % md;
		if (ip > (lim >> FB)) begin
			sat = 1;
			val = lim;
		end else begin
			val = (ip << FB) + ((rem << FB) / md);
			if (val > lim) begin
				sat = 1;
				val = lim;
			end
		end
		if (neg)
			val = -val;
		return val[CW-1:0];
	endfunction

	function automatic vertex_result_t project_vertex(logic signed [CW-1:0] x,
			logic signed [CW-1:0] y, logic lst);
		vertex_result_t r;
		longint tx, ty, tw;
		bit sat;
		sat = 0;
		tx = row_dot(row_x, x, y);
		ty = row_dot(row_y, x, y);
		tw = row_dot(row_w, x, y);
		r.lst = lst;
		if (tw == 0) begin
			r.px = '0;
			r.py = '0;
			r.st = STATUS_WZERO;
		end else begin
			r.px = divide_clamp(tx, tw, sat);
			r.py = divide_clamp(ty, tw, sat);
			r.st = sat ? STATUS_SAT : STATUS_OK;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// receiver side: random stall and compare
	always @(posedge clk) begin
		vertex_result_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (projected_queue.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					e = projected_queue.pop_front();
					if (projected_x !== e.px) report_mismatch("projected_x", projected_x, e.px);
					if (projected_y !== e.py) report_mismatch("projected_y", projected_y, e.py);
					if (status !== e.st) report_mismatch("status", status, e.st);
					if (last_out !== e.lst) report_mismatch("last_out", last_out, e.lst);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic lst,
			bit known, vertex_result_t want);
		vertex_result_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		p = project_vertex(x, y, lst);
		if (known && (p.px !== want.px || p.py !== want.py || p.st !== want.st))
			report_mismatch("table row", p.px, want.px);
		in_valid <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		last_vertex <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		projected_queue.push_back(p);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (projected_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_row(logic [INDEX_WIDTH-1:0] idx, logic [ROW_WIDTH-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ROW_X: row_x = val;
			REG_ROW_Y: row_y = val;
			REG_ROW_W: row_w = val;
			default: ;
		endcase
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return CW'($urandom_range(255));
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(6))
			0: return 16'h0100;
			1: return 16'h0000;
			2: return 16'h7fff;
			3: return 16'h8000;
			4: return 16'(int'($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	stim_row_t table_rows[$];

	function automatic stim_row_t mk(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic lst, bit known, logic signed [CW-1:0] px, logic signed [CW-1:0] py,
			logic [1:0] st);
		stim_row_t r;
		r.x = x; r.y = y; r.lst = lst; r.known = known;
		r.res.px = px; r.res.py = py; r.res.st = st; r.res.lst = lst;
		return r;
	endfunction

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		vertex_result_t none;
		none = '{default: '0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset: outputs equal inputs
		table_rows.push_back(mk(16'sh0000, 16'sh0000, 0, 1, 16'sh0000, 16'sh0000, STATUS_OK));
		table_rows.push_back(mk(16'sh7fff, 16'sh8000, 1, 1, 16'sh7fff, 16'sh8000, STATUS_OK));
		table_rows.push_back(mk(16'sh8000, 16'sh7fff, 0, 1, 16'sh8000, 16'sh7fff, STATUS_OK));
		table_rows.push_back(mk(16'sh0100, -16'sh0100, 1, 1, 16'sh0100, -16'sh0100, STATUS_OK));
		table_rows.push_back(mk(16'sh1234, 16'shedcb, 0, 1, 16'sh1234, 16'shedcb, STATUS_OK));
		send_idle_pct = 12;
		recv_idle_pct = 71;
		foreach (table_rows[i])
			send_vertex(table_rows[i].x, table_rows[i].y, table_rows[i].lst,
				table_rows[i].known, table_rows[i].res);
		drain();

		// w row zero: every result flagged and zeroed
		write_row(REG_ROW_W, 48'h0);
		send_vertex(16'sh7fff, 16'sh7fff, 1, 1, '{16'sh0, 16'sh0, STATUS_WZERO, 1'b1});
		send_vertex(16'sh8000, 16'sh0001, 0, 1, '{16'sh0, 16'sh0, STATUS_WZERO, 1'b0});
		drain();
		// w = 1/256: scale up by 256, saturates both directions
		write_row(REG_ROW_W, 48'h0001_0000_0000);
		send_vertex(16'sh7fff, 16'sh8000, 0, 1, '{16'sh7fff, 16'sh8000, STATUS_SAT, 1'b0});
		send_vertex(16'sh0001, -16'sh0001, 1, 1, '{16'sh0100, -16'sh0100, STATUS_OK, 1'b1});
		// w = -1: negation, most negative input saturates
		drain();
		write_row(REG_ROW_W, 48'hff00_0000_0000);
		send_vertex(16'sh8000, 16'sh0005, 0, 1, '{16'sh7fff, -16'sh0005, STATUS_SAT, 1'b0});
		// w depends on x so x = 0 gives w zero
		drain();
		write_row(REG_ROW_W, 48'h0000_0000_0100);
		send_vertex(16'sh0000, 16'sh0300, 1, 1, '{16'sh0, 16'sh0, STATUS_WZERO, 1'b1});
		send_vertex(16'sh0300, 16'sh0000, 0, 0, none);
		send_vertex(-16'sh0200, 16'sh0123, 1, 0, none);
		drain();
		// extreme rows
		write_row(REG_ROW_X, 48'h8000_7fff_8000);
		write_row(REG_ROW_Y, 48'h7fff_8000_7fff);
		write_row(REG_ROW_W, 48'h7fff_7fff_7fff);
		send_vertex(16'sh7fff, 16'sh7fff, 0, 0, none);
		send_vertex(16'sh8000, 16'sh8000, 1, 0, none);
		send_vertex(16'sh8000, 16'sh7fff, 0, 0, none);
		drain();

		// random phases over several matrices and idling patterns
		for (int ph = 0; ph < 16; ph++) begin
			if (ph == 5) begin
				send_idle_pct = 71;
				recv_idle_pct = 12;
			end else if (ph == 11) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_row(REG_ROW_X, {rand_coef(), rand_coef(), rand_coef()});
			write_row(REG_ROW_Y, {rand_coef(), rand_coef(), rand_coef()});
			write_row(REG_ROW_W, {rand_coef(), rand_coef(), rand_coef()});
			for (int k = 0; k < 100; k++) begin
				send_vertex(rand_coord(), rand_coord(), 1'($urandom), 0, none);
				// pause until the pipeline is empty
				if (k == 50 && ph == 3) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (projected_queue.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		repeat (LATENCY) @(posedge clk);
		if (errors == 0 && projected_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
